@@ design/ulht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulht_pkg
// Shared types and constants of the update loss history tracker.
// ----------------------------------------------------------------------------
package ulht_pkg;

    // request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam int CNT_W       = 32;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 32;
    localparam int MAX_RD_BITS = DIGIT_W * MAX_DIGITS;
    localparam int HSIZE_W     = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic calc;      // compute the loss
        logic update;    // update counters and history
        logic load;      // load next digit into the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register empty or draining this cycle
        logic last_digit;  // digit being offered is the final one
    } ctrl_stat_t;

endpackage

@@ design/update_loss_history_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_loss_history_tracker_top
// Sequence-gap loss tracker with wrapping counters and a history readout.
// ----------------------------------------------------------------------------
// Flow: the input transfer captures the item, then come the loss calc, the state
//   update and the first digit load into the output register (held while it is full).
// Items: one at a time, each read out as ndig digits, ndig = ceil(bits read / 4),
//   1 for a clear or a disabled readout, at most 32.
// Reset: async active low; counters, history and readout length go to zero.
// ----------------------------------------------------------------------------
module update_loss_history_tracker_top #(
    parameter int HIST_BITS = 128   // history ring length, 4 to 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: readout length write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ulht_pkg::HSIZE_W-1:0]  hist_len,
    // input items
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          req_type,
    input  logic                          prior_valid,
    input  logic signed [31:0]            new_seq,
    input  logic signed [31:0]            old_seq,
    input  logic signed [31:0]            new_start,
    input  logic signed [31:0]            old_start,
    // result items
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ulht_pkg::CNT_W-1:0]    total_count,
    output logic [ulht_pkg::CNT_W-1:0]    expected_count,
    output logic [ulht_pkg::CNT_W-1:0]    lost_count,
    output logic [ulht_pkg::DIGIT_W-1:0]  hex_digit,
    output logic                          digit_valid,
    output logic                          last
);

    ulht_pkg::ctrl_cmd_t  cmd;
    ulht_pkg::ctrl_stat_t stat;

    // the user must make register writes only while idle (not enforced here); the port is always open
    assign cfg_ready = 1'b1;

    // sequencer: one item at a time, the output register lets the next
    // item be accepted while the final digit still waits for its transfer
    ulht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // history is kept newest-first, so an update is a shift by loss + 1
    // and the readout walks 4-bit slices from bit 0 upward
    ulht_datapath #(
        .HIST_BITS (HIST_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (hist_len),
        .req_type       (req_type),
        .prior_valid    (prior_valid),
        .new_seq        (new_seq),
        .old_seq        (old_seq),
        .new_start      (new_start),
        .old_start      (old_start),
        .result_stall   (result_stall),
        .result_valid   (result_valid),
        .total_count    (total_count),
        .expected_count (expected_count),
        .lost_count     (lost_count),
        .hex_digit      (hex_digit),
        .digit_valid    (digit_valid),
        .last           (last)
    );

    // an accepted item blocks further input until its last digit is loaded
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input accepted twice in a row");

    // an empty result is a single, final, zero digit
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !digit_valid |-> last && (hex_digit == '0))
        else $error("empty result not final or not zero");

    // after a non-final transfer the next digit is already loaded
    a_digit_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last |=> result_valid)
        else $error("gap in digit stream");

    // counters on one item's results do not move between its digits
    a_counts_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last |=>
            $stable(total_count) && $stable(lost_count) && $stable(expected_count))
        else $error("counters changed inside one readout");

endmodule

@@ design/ulht_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulht_ctrl
// Sequencer: capture, loss calc, state update, then one digit per transfer.
// ----------------------------------------------------------------------------
module ulht_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  ulht_pkg::ctrl_stat_t  stat,
    output ulht_pkg::ctrl_cmd_t   cmd
);

    ulht_pkg::state_t state_reg;
    ulht_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ulht_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ulht_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ulht_pkg::ST_CALC;
                end
            end
            ulht_pkg::ST_CALC:
            begin
                state_next = ulht_pkg::ST_UPDATE;
            end
            ulht_pkg::ST_UPDATE:
            begin
                state_next = ulht_pkg::ST_EMIT;
            end
            ulht_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.last_digit)
                begin
                    state_next = ulht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ulht_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = 1'b1;
        cmd         = '0;
        unique case (state_reg)
            ulht_pkg::ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ulht_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ulht_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ulht_pkg::ST_EMIT:
            begin
                cmd.load = stat.out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ design/ulht_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulht_datapath
// Item registers, loss calc, counters, history shift register, digit readout.
// ----------------------------------------------------------------------------
module ulht_datapath #(
    parameter int HIST_BITS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ulht_pkg::ctrl_cmd_t           cmd,
    output ulht_pkg::ctrl_stat_t          stat,
    input  logic                          cfg_we,
    input  logic [ulht_pkg::HSIZE_W-1:0]  cfg_data,
    input  logic                          req_type,
    input  logic                          prior_valid,
    input  logic signed [31:0]            new_seq,
    input  logic signed [31:0]            old_seq,
    input  logic signed [31:0]            new_start,
    input  logic signed [31:0]            old_start,
    input  logic                          result_stall,
    output logic                          result_valid,
    output logic [ulht_pkg::CNT_W-1:0]    total_count,
    output logic [ulht_pkg::CNT_W-1:0]    expected_count,
    output logic [ulht_pkg::CNT_W-1:0]    lost_count,
    output logic [ulht_pkg::DIGIT_W-1:0]  hex_digit,
    output logic                          digit_valid,
    output logic                          last
);

    localparam int HMAX   = (HIST_BITS < ulht_pkg::MAX_RD_BITS) ? HIST_BITS
                                                                : ulht_pkg::MAX_RD_BITS;
    localparam int ND_MAX = (HMAX + ulht_pkg::DIGIT_W - 1) / ulht_pkg::DIGIT_W;
    localparam int IDX_W  = (ND_MAX > 1) ? $clog2(ND_MAX) : 1;
    localparam int PADW   = ulht_pkg::DIGIT_W * ND_MAX;
    localparam int LW     = $clog2(HIST_BITS + 1);
    localparam int SHW    = LW + 1;
    localparam logic [ulht_pkg::HSIZE_W-1:0] HMAX_V = ulht_pkg::HSIZE_W'(HMAX);
    localparam logic [HIST_BITS-1:0] ONES_H = {HIST_BITS{1'b1}};

    // captured item
    logic              req_reg;
    logic              prior_reg;
    logic signed [31:0] nseq_reg;
    logic signed [31:0] oseq_reg;
    logic [31:0]       nst_reg;
    logic [31:0]       ost_reg;

    logic [31:0]       loss_reg;
    logic [31:0]       loss_next;
    logic              seq_reg;

    logic [ulht_pkg::HSIZE_W-1:0] hsize_reg;
    logic [ulht_pkg::CNT_W-1:0]   total_reg;
    logic [ulht_pkg::CNT_W-1:0]   expected_reg;
    logic [ulht_pkg::CNT_W-1:0]   lost_reg;
    // ring kept newest-first: bit 0 is the most recent history bit
    logic [HIST_BITS-1:0]         ring_reg;
    logic [HIST_BITS-1:0]         ring_next;
    logic [IDX_W-1:0]             dig_reg;

    logic                         out_valid_reg;
    logic [ulht_pkg::CNT_W-1:0]   out_total_reg;
    logic [ulht_pkg::CNT_W-1:0]   out_expected_reg;
    logic [ulht_pkg::CNT_W-1:0]   out_lost_reg;
    logic [ulht_pkg::DIGIT_W-1:0] out_digit_reg;
    logic                         out_dvalid_reg;
    logic                         out_last_reg;

    logic signed [31:0]           want;
    logic [LW-1:0]                loss_sat;
    logic [SHW-1:0]               shamt;
    logic [PADW-1:0]              hist_pad;
    logic [ulht_pkg::HSIZE_W-1:0] nbits;
    logic [ulht_pkg::HSIZE_W-1:0] ndig_m1;
    logic                         empty;
    logic                         last_dig;
    logic [ulht_pkg::DIGIT_W-1:0] raw;
    logic [ulht_pkg::DIGIT_W-1:0] digit;
    logic [ulht_pkg::HSIZE_W-1:0] bit_idx [ulht_pkg::DIGIT_W];

    // loss: 0 without a prior item, on a start mismatch or in order; 1 if new is behind old+1, else the gap
    always_comb
    begin
        want      = oseq_reg + 32'sd1;
        loss_next = '0;
        if (prior_reg && (nst_reg == ost_reg) && (want != nseq_reg))
        begin
            if (nseq_reg < want)
            begin
                loss_next = 32'd1;
            end
            else
            begin
                loss_next = 32'(nseq_reg - want);
            end
        end
    end

    // shift in loss ones then one zero; large loss fills all but bit 0
    always_comb
    begin
        if (loss_reg >= 32'(HIST_BITS))
        begin
            loss_sat = LW'(HIST_BITS);
        end
        else
        begin
            loss_sat = loss_reg[LW-1:0];
        end
        shamt     = SHW'(loss_sat) + SHW'(1);
        ring_next = (ring_reg << shamt) | ((ONES_H << 1) & ~(ONES_H << shamt));
    end

    genvar gj;
    generate
        for (gj = 0; gj < PADW; gj++)
        begin : g_pad
            if (gj < HIST_BITS)
            begin : g_bit
                assign hist_pad[gj] = ring_reg[gj];
            end
            else
            begin : g_zero
                assign hist_pad[gj] = 1'b0;
            end
        end
    endgenerate

    // digit readout
    always_comb
    begin
        nbits    = (hsize_reg > HMAX_V) ? HMAX_V : hsize_reg;
        ndig_m1  = (nbits - 8'd1) >> 2;
        empty    = (req_reg == ulht_pkg::REQ_CLEAR) || (nbits == '0);
        last_dig = empty || (dig_reg == ndig_m1[IDX_W-1:0]);
        raw      = hist_pad[{dig_reg, 2'b00} +: ulht_pkg::DIGIT_W];
        for (int i = 0; i < ulht_pkg::DIGIT_W; i++)
        begin
            bit_idx[i] = ulht_pkg::HSIZE_W'({dig_reg, 2'(i)});
            digit[ulht_pkg::DIGIT_W-1-i] = raw[i] && (bit_idx[i] < nbits);
        end
    end

    assign stat.out_free   = !out_valid_reg || !result_stall;
    assign stat.last_digit = last_dig;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            prior_reg <= prior_valid;
            nseq_reg  <= new_seq;
            oseq_reg  <= old_seq;
            nst_reg   <= new_start;
            ost_reg   <= old_start;
        end
        if (cmd.calc)
        begin
            loss_reg <= loss_next;
            seq_reg  <= prior_reg;
        end
        if (cmd.load)
        begin
            out_total_reg    <= total_reg;
            out_expected_reg <= expected_reg;
            out_lost_reg     <= lost_reg;
            out_digit_reg    <= empty ? '0 : digit;
            out_dvalid_reg   <= !empty;
            out_last_reg     <= last_dig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsize_reg     <= '0;
            total_reg     <= '0;
            expected_reg  <= '0;
            lost_reg      <= '0;
            ring_reg      <= '0;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hsize_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                dig_reg <= '0;
                if (req_reg == ulht_pkg::REQ_CLEAR)
                begin
                    total_reg    <= '0;
                    expected_reg <= '0;
                    lost_reg     <= '0;
                    ring_reg     <= '0;
                end
                else
                begin
                    total_reg    <= total_reg + 32'd1;
                    expected_reg <= expected_reg + loss_reg + 32'(seq_reg);
                    lost_reg     <= lost_reg + loss_reg;
                    ring_reg     <= ring_next;
                end
            end
            else if (cmd.load)
            begin
                dig_reg <= dig_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid   = out_valid_reg;
    assign total_count    = out_total_reg;
    assign expected_count = out_expected_reg;
    assign lost_count     = out_lost_reg;
    assign hex_digit      = out_digit_reg;
    assign digit_valid    = out_dvalid_reg;
    assign last           = out_last_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the update loss history tracker. Directed updates
// hit the sequence corner cases (behind, gaps, wrap, huge loss, clears).
// Constrained-by-hand random streams follow under a sweep of readout
// lengths. Both handshakes idle and stall at random. Every digit is checked
// against a predictor that keeps its own counters and history ring.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RING_LEN    = 128;   // history ring length of the instance
    localparam int RING_IW     = $clog2(RING_LEN);
    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES = 40;    // quiet time after the last digit
    localparam int PHASE_ITEMS = 23;    // random updates per readout length

    // one readout digit plus the counters it carries
    typedef struct packed {
        logic [ulht_pkg::CNT_W-1:0]   total;
        logic [ulht_pkg::CNT_W-1:0]   sequenced;
        logic [ulht_pkg::CNT_W-1:0]   lost;
        logic [ulht_pkg::DIGIT_W-1:0] digit;
        logic                         dvalid;
        logic                         fin;
    } digit_rec_t;

    // ------------------------------------------------------------------------
    // Loss/history predictor and the queue of digits it expects
    // ------------------------------------------------------------------------
    class loss_scoreboard;
        bit [ulht_pkg::CNT_W-1:0]   total_cnt;
        bit [ulht_pkg::CNT_W-1:0]   expected_cnt;
        bit [ulht_pkg::CNT_W-1:0]   lost_cnt;
        bit [RING_LEN-1:0]          ring;
        int unsigned                ptr;
        bit [ulht_pkg::HSIZE_W-1:0] size;
        digit_rec_t                 digit_q[$];
        int unsigned                mismatches;
        int unsigned                digits_seen;
        int unsigned                updates;
        int unsigned                clears;

        function void set_size(bit [ulht_pkg::HSIZE_W-1:0] v);
            size = v;
        endfunction

        function void push_digit(bit [ulht_pkg::DIGIT_W-1:0] d, bit dv, bit fin);
            digit_rec_t r;
            r.total     = total_cnt;
            r.sequenced = expected_cnt;
            r.lost      = lost_cnt;
            r.digit     = d;
            r.dvalid    = dv;
            r.fin       = fin;
            digit_q.push_back(r);
        endfunction

        function void note_item(bit rq, bit pv, bit [31:0] ns, bit [31:0] os,
                                bit [31:0] nst, bit [31:0] ost);
            bit [31:0]                    want;
            bit [31:0]                    loss;
            int unsigned                  nbits;
            int unsigned                  ndig;
            int unsigned                  pos;
            int unsigned                  i;
            bit [ulht_pkg::DIGIT_W-1:0]   dig;
            if (rq == ulht_pkg::REQ_CLEAR)
            begin
                // pointer survives a clear
                clears++;
                total_cnt    = '0;
                expected_cnt = '0;
                lost_cnt     = '0;
                ring         = '0;
                push_digit('0, 1'b0, 1'b1);
                return;
            end
            updates++;
            loss = '0;
            if (pv)
            begin
                want = os + 32'd1;
                if (nst == ost && want != ns)
                    loss = ($signed(ns) < $signed(want)) ? 32'd1 : ns - want;
            end
            total_cnt    += 32'd1;
            expected_cnt += loss + {31'd0, pv};
            lost_cnt     += loss;
            if (loss >= RING_LEN)
                ring = '1;
            else
                for (i = 0; i < loss; i++)
                    ring[RING_IW'((ptr + i) % RING_LEN)] = 1'b1;
            ptr = (ptr + loss % RING_LEN) % RING_LEN;
            ring[RING_IW'(ptr)] = 1'b0;
            ptr = (ptr + 1) % RING_LEN;

            nbits = 32'(size);
            if (nbits > RING_LEN)
                nbits = RING_LEN;
            if (nbits > ulht_pkg::MAX_RD_BITS)
                nbits = ulht_pkg::MAX_RD_BITS;
            if (nbits == 0)
            begin
                push_digit('0, 1'b0, 1'b1);
                return;
            end
            ndig = (nbits + 3) / 4;
            pos  = (ptr + RING_LEN - 1) % RING_LEN;
            dig  = '0;
            for (i = 0; i < nbits; i++)
            begin
                if (ring[RING_IW'(pos)])
                    dig[2'(3 - (i % 4))] = 1'b1;
                pos = (pos + RING_LEN - 1) % RING_LEN;
                if (i % 4 == 3 || i + 1 == nbits)
                begin
                    push_digit(dig, 1'b1, (i / 4 + 1 == ndig));
                    dig = '0;
                end
            end
        endfunction

        function void flag(string what, digit_rec_t e, digit_rec_t g);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t %s: exp tot=%h seq=%h lost=%h dig=%h dv=%b last=%b",
                         $time, what, e.total, e.sequenced, e.lost, e.digit,
                         e.dvalid, e.fin);
                $display("    got tot=%h seq=%h lost=%h dig=%h dv=%b last=%b",
                         g.total, g.sequenced, g.lost, g.digit, g.dvalid, g.fin);
            end
        endfunction

        function void check_result(digit_rec_t got);
            digit_rec_t exp_d;
            digits_seen++;
            if (digit_q.size() == 0)
            begin
                flag("unexpected digit", '0, got);
                return;
            end
            exp_d = digit_q.pop_front();
            if (got !== exp_d)
                flag("digit mismatch", exp_d, got);
        endfunction

        function int unsigned outstanding();
            return digit_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n = 1'b0;

    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [ulht_pkg::HSIZE_W-1:0]  cfg_size    = '0;
    logic                          item_valid  = 1'b0;
    logic                          item_stall;
    logic                          req_type_i  = ulht_pkg::REQ_RECORD;
    logic                          prior_i     = 1'b0;
    logic signed [31:0]            new_seq_i   = '0;
    logic signed [31:0]            old_seq_i   = '0;
    logic signed [31:0]            new_start_i = '0;
    logic signed [31:0]            old_start_i = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [ulht_pkg::CNT_W-1:0]    total_count;
    logic [ulht_pkg::CNT_W-1:0]    expected_count;
    logic [ulht_pkg::CNT_W-1:0]    lost_count;
    logic [ulht_pkg::DIGIT_W-1:0]  hex_digit;
    logic                          digit_valid;
    logic                          last;

    loss_scoreboard sb;

    bit          quiet = 1'b0;    // no idling on either side while set
    int          rx_hold = 0;     // remaining result-side stall cycles
    int          idle_cycles = 0; // watchdog: cycles since the last transfer
    int unsigned settings_used = 0;
    logic [31:0] cur_seq;         // running sender stream for random updates
    logic [31:0] cur_start;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    update_loss_history_tracker_top #(
        .HIST_BITS      (RING_LEN)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .hist_len       (cfg_size),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .req_type       (req_type_i),
        .prior_valid    (prior_i),
        .new_seq        (new_seq_i),
        .old_seq        (old_seq_i),
        .new_start      (new_start_i),
        .old_start      (old_start_i),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .total_count    (total_count),
        .expected_count (expected_count),
        .lost_count     (lost_count),
        .hex_digit      (hex_digit),
        .digit_valid    (digit_valid),
        .last           (last)
    );

    // mostly back-to-back, sometimes a few cycles, now and then a long hole
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: inputs are sampled on the accepting edge, before any NBA of
    // that edge lands, so predictor and checker see exactly what transferred.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(req_type_i, prior_i, new_seq_i, old_seq_i,
                         new_start_i, old_start_i);
        if (rst_n && result_valid && !result_stall)
            sb.check_result({total_count, expected_count, lost_count,
                             hex_digit, digit_valid, last});
    end

    // Result-side back-pressure in bursts; held off while quiet is set.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
            rx_hold--;
        else if (rst_n && !quiet)
            rx_hold = pick_gap();
        result_stall <= (rx_hold > 0);
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d digits still owed",
                         STALL_LIMIT, sb.outstanding());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Present one request and hold it until the block takes it; then maybe
    // drop valid for a random gap. Valid is never toggled within one step.
    task automatic send_item(input logic rq, input logic pv,
                             input logic [31:0] ns, input logic [31:0] os,
                             input logic [31:0] nst, input logic [31:0] ost);
        int gap;
        item_valid  <= 1'b1;
        req_type_i  <= rq;
        prior_i     <= pv;
        new_seq_i   <= ns;
        old_seq_i   <= os;
        new_start_i <= nst;
        old_start_i <= ost;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_update(input logic [31:0] ns, input logic [31:0] os,
                               input logic [31:0] nst, input logic [31:0] ost);
        send_item(ulht_pkg::REQ_RECORD, 1'b1, ns, os, nst, ost);
    endtask

    // Sender holds off until every owed digit has come back, then lets the
    // block fall back to idle before config changes.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle (after reset or after drain_results).
    task automatic write_size(input logic [ulht_pkg::HSIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_size  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(v);
        settings_used++;
    endtask

    // Mostly well-formed streams from one sender (in order, small gaps,
    // reordering, big and huge jumps, restarts), plus clears and noise.
    task automatic run_random(input int n);
        int          r;
        int          k;
        logic [31:0] ns;
        logic [31:0] nst;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(ulht_pkg::REQ_CLEAR, 1'($urandom_range(0, 1)), $urandom(),
                          $urandom(), $urandom(), $urandom());
            else if (r < 12)
            begin
                // noise: fields unrelated, start times equal only by chance
                nst = $urandom();
                send_item(ulht_pkg::REQ_RECORD, 1'($urandom_range(0, 1)), $urandom(),
                          $urandom(), nst,
                          ($urandom_range(0, 1) == 1) ? nst : $urandom());
            end
            else if (r < 18)
                send_item(ulht_pkg::REQ_RECORD, 1'b0, $urandom(), $urandom(),
                          $urandom(), $urandom());
            else
            begin
                nst = cur_start;
                r = $urandom_range(0, 99);
                if (r < 55)
                    ns = cur_seq + 32'd1;
                else if (r < 70)
                    ns = cur_seq + 32'd1 + $urandom_range(1, 6);
                else if (r < 78)
                    ns = cur_seq - $urandom_range(0, 5);
                else if (r < 84)
                    ns = cur_seq + $urandom_range(100, 300);
                else if (r < 87)
                    ns = cur_seq + 32'd1 + $urandom();
                else
                begin
                    // sender restart: new start time, fresh sequence base,
                    // often parked just below a sign or unsigned wrap
                    nst = $urandom();
                    case ($urandom_range(0, 3))
                        0:       ns = $urandom();
                        1:       ns = 32'h7fff_fff0 + $urandom_range(0, 15);
                        2:       ns = 32'hffff_fff0 + $urandom_range(0, 15);
                        default: ns = $urandom_range(0, 1000);
                    endcase
                end
                send_update(ns, cur_seq, nst, cur_start);
                cur_seq   = ns;
                cur_start = nst;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [ulht_pkg::HSIZE_W-1:0] sweep[10];
        logic [31:0]                  st;
        int                           p;
        int unsigned                  leftover;

        sb = new();
        sweep = '{8'd1, 8'd128, 8'd5, 8'd0, 8'd64, 8'd129, 8'd2, 8'd3, 8'd7, 8'd0};
        sweep[9] = ulht_pkg::HSIZE_W'($urandom_range(0, 255));
        st = 32'h1234_5678;
        cur_seq = 32'd100;
        cur_start = st;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // readout disabled by the reset value of the readout length
        send_item(ulht_pkg::REQ_RECORD, 1'b0, '0, '0, '0, '0);
        send_update(32'd9, 32'd5, st, st);
        send_item(ulht_pkg::REQ_CLEAR, 1'b0, '1, '1, '1, '1);
        drain_results();

        // oversized readout request saturates to 32 digits
        write_size(8'd255);
        send_update(32'd6, 32'd5, st, st);                 // in order
        send_update(32'd10, 32'd6, st, st);                // gap of three
        send_update(32'd3, 32'd10, st, st);                // behind
        send_update(32'd3, 32'd3, st, st);                 // repeat counts as behind
        send_update(32'd50, 32'd3, st, st + 32'd1);        // restart, no loss
        send_update(32'h8000_0000, 32'h7fff_ffff, st, st); // old+1 crosses the sign
        send_update(32'h7fff_fff0, 32'h7fff_ffff, st, st); // old+1 wraps negative: a huge gap
        send_update(32'h0000_0000, 32'hffff_ffff, st, st); // unsigned wrap in order
        send_update(32'd127, 32'd0, st, st);               // loss 126
        send_update(32'd128, 32'd0, st, st);               // loss 127, just fits
        send_update(32'd129, 32'd0, st, st);               // loss 128 fills the ring
        send_update(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        // ^ old+1 is most negative: loss is all ones, expected count wraps
        send_item(ulht_pkg::REQ_RECORD, 1'b0, '1, '1, '1, '1);
        send_item(ulht_pkg::REQ_RECORD, 1'b1, '0, '0, '0, '1);   // start mismatch
        send_item(ulht_pkg::REQ_CLEAR, 1'b1, '0, '0, '0, '0);
        send_update(32'd300, 32'd0, st, st);               // huge loss after clear
        send_update(32'd301, 32'd300, st, st);
        drain_results();

        // random streams under a sweep of readout lengths; every third
        // phase runs with no idling on either side
        for (p = 0; p < 10; p++)
        begin
            write_size(sweep[p]);
            quiet = (p % 3 == 2);
            run_random(PHASE_ITEMS);
            drain_results();
        end
        quiet = 1'b0;

        // late or extra digits would land here
        repeat (TAIL_CYCLES) @(posedge clk);
        leftover = sb.outstanding();
        if (leftover != 0)
            $display("%0d expected digits never arrived", leftover);
        if (sb.mismatches > 10)
            $display("%0d mismatches in total, first 10 shown", sb.mismatches);

        $display("coverage: %0d updates and %0d clears, %0d digits checked",
                 sb.updates, sb.clears, sb.digits_seen);
        $display("readout length written %0d times, from disabled through saturated",
                 settings_used);

        if (sb.mismatches == 0 && leftover == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ulht_pkg.sv
design/ulht_ctrl.sv
design/ulht_datapath.sv
design/update_loss_history_tracker_top.sv
bench/tb_top.sv
